// ===== sv/ising_metropolis_flip_macros.svh =====
// Assertion helpers shared by the lattice update logic.
`ifndef ISING_METROPOLIS_FLIP_MACROS_SVH
`define ISING_METROPOLIS_FLIP_MACROS_SVH

// Checked on every rising edge, switched off while reset is held.
`define IMF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked on every rising edge, also while reset is held.
`define IMF_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== sv/imf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imf_pkg
// Shared constants of the Ising lattice update block: lattice size, widths,
// operation codes and register indexes.
// ----------------------------------------------------------------------------
package imf_pkg;

  // Largest lattice side; the row memory holds MAX_SIDE rows of MAX_SIDE spins.
  localparam int MAX_SIDE = 64;
  localparam int AW       = $clog2(MAX_SIDE);
  // Width that holds the effective side itself and the 7-bit side register.
  localparam int NW       = ($clog2(MAX_SIDE + 1) > 7) ? $clog2(MAX_SIDE + 1) : 7;

  localparam int COORD_W  = 6;
  localparam int THR_W    = 33;
  localparam int UNI_W    = 32;
  localparam int CNT_W    = 32;
  localparam int DE_W     = 5;
  localparam int SIDE_W   = 7;

  // Operation codes.
  localparam logic [1:0] OP_LOAD  = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_FLIP  = 2'd2;
  localparam logic [1:0] OP_CLEAR = 2'd3;

  // Register indexes on the configuration port.
  localparam logic [2:0] REG_SIDE   = 3'd0;
  localparam logic [2:0] REG_THR_M8 = 3'd1;
  localparam logic [2:0] REG_THR_M4 = 3'd2;
  localparam logic [2:0] REG_THR_P4 = 3'd3;
  localparam logic [2:0] REG_THR_P8 = 3'd4;

  localparam logic [THR_W-1:0] THR_ONE = {1'b1, {(THR_W-1){1'b0}}};

endpackage

// ===== sv/imf_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imf_ram
// Generic simple dual-port RAM: one write port, one read port with the read
// data registered.
// ----------------------------------------------------------------------------
module imf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    rd_data_o <= mem[rd_addr_i];
  end

endmodule

// ===== sv/ising_metropolis_flip.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ising_metropolis_flip
// Metropolis single-spin-flip engine for a periodic square Ising lattice.
// ----------------------------------------------------------------------------
// The lattice lives in one row memory, MAX_SIDE words of MAX_SIDE spins, with
// a single registered read port, and the block handles one item at a time.
// An attempted flip reads the site's own row, then the row above, then the
// row below, and writes it back in a finish step if the flip is accepted.
// A load or a read does one row read, then the finish; a counter clear or
// an item with a bad site goes straight to the finish. Results sit in an
// output register, so the next item is taken while a result still waits;
// only the finish step waits for that register to drain. The lattice has no
// reset: read only sites that have been loaded. Configuration is to be
// written only while the block is idle; the block does not enforce it.
module ising_metropolis_flip
  import imf_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  // Configuration write port.
  input  logic              cfg_we_i,
  input  logic [2:0]        cfg_idx_i,
  input  logic [THR_W-1:0]  cfg_data_i,
  // Input items.
  input  logic              s_axis_tvalid_i,
  output logic              s_axis_tready_o,
  // tdata from bit 0: row[5:0], col[11:6], spin_in[12], uniform[44:13], zero fill.
  input  logic [47:0]       s_axis_tdata_i,
  // tuser from bit 0: op[1:0].
  input  logic [1:0]        s_axis_tuser_i,
  // Result items.
  output logic              m_axis_tvalid_o,
  input  logic              m_axis_tready_i,
  // tdata from bit 0: spin_out[0], accepted[1], energy_change[6:2],
  // accept_total[38:7], zero fill.
  output logic [39:0]       m_axis_tdata_o,
  // tuser from bit 0: bad_site[0].
  output logic              m_axis_tuser_o
);

`include "ising_metropolis_flip_macros.svh"

  // Sequencer states.
  localparam logic [2:0] ST_IDLE = 3'd0;  // take an item, read its own row
  localparam logic [2:0] ST_CTR  = 3'd1;  // own row arrives, read row above
  localparam logic [2:0] ST_UP   = 3'd2;  // row above arrives, read row below
  localparam logic [2:0] ST_DN   = 3'd3;  // row below arrives
  localparam logic [2:0] ST_FIN  = 3'd4;  // decide, write back, emit result

  logic [2:0] state_q, state_d;

  // Configuration registers.
  logic [SIDE_W-1:0] side_q;
  logic [THR_W-1:0]  thr_m8_q, thr_m4_q, thr_p4_q, thr_p8_q;

  // Item registers.
  logic [1:0]         op_q;
  logic [COORD_W-1:0] row_q, col_q;
  logic               spin_in_q;
  logic [UNI_W-1:0]   uni_q;
  logic               bad_q;
  logic [MAX_SIDE-1:0] ctr_row_q;
  logic               up_q, dn_q;

  logic [CNT_W-1:0]   cnt_q;

  // Output register.
  logic               out_valid_q;
  logic               out_spin_q, out_acc_q, out_bad_q;
  logic [DE_W-1:0]    out_de_q;
  logic [CNT_W-1:0]   out_cnt_q;

  // Effective side: the register clamped to 2..MAX_SIDE.
  logic [NW-1:0] side_ext, n_eff;
  assign side_ext = NW'(side_q);
  always_comb begin
    if (side_ext < NW'(2)) begin
      n_eff = NW'(2);
    end else if (side_ext > NW'(MAX_SIDE)) begin
      n_eff = NW'(MAX_SIDE);
    end else begin
      n_eff = side_ext;
    end
  end

  // Incoming fields.
  logic [1:0]         in_op;
  logic [COORD_W-1:0] in_row, in_col;
  logic [NW-1:0]      in_row_ext, in_col_ext;
  logic               in_bad, in_fire;
  assign in_op      = s_axis_tuser_i;
  assign in_row     = s_axis_tdata_i[5:0];
  assign in_col     = s_axis_tdata_i[11:6];
  assign in_row_ext = NW'(in_row);
  assign in_col_ext = NW'(in_col);
  assign in_bad     = (in_row_ext >= n_eff) || (in_col_ext >= n_eff);

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;

  // Wrapped neighbour coordinates of the held site.
  logic [NW-1:0] row_ext, col_ext, up_row, dn_row, lf_col, rt_col;
  assign row_ext = NW'(row_q);
  assign col_ext = NW'(col_q);
  assign up_row  = (row_ext == '0) ? n_eff - NW'(1) : row_ext - NW'(1);
  assign dn_row  = (row_ext + NW'(1) == n_eff) ? '0 : row_ext + NW'(1);
  assign lf_col  = (col_ext == '0) ? n_eff - NW'(1) : col_ext - NW'(1);
  assign rt_col  = (col_ext + NW'(1) == n_eff) ? '0 : col_ext + NW'(1);

  // Row memory.
  logic                wr_en;
  logic [AW-1:0]       wr_addr, rd_addr;
  logic [MAX_SIDE-1:0] wr_data, rd_data;

  always_comb begin
    case (state_q)
      ST_CTR:  rd_addr = up_row[AW-1:0];
      ST_UP:   rd_addr = dn_row[AW-1:0];
      default: rd_addr = in_row_ext[AW-1:0];
    endcase
  end

  imf_ram #(
    .WIDTH (MAX_SIDE),
    .DEPTH (MAX_SIDE)
  ) u_lattice (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  // Energy change. With k neighbours at +1, the count of neighbours aligned
  // with the site is e = k for spin +1 and 4 - k for spin -1, and dE = 4e - 8.
  logic       ctr_spin, lf_spin, rt_spin;
  logic [2:0] up_cnt, k_cnt, e_cnt;
  logic [DE_W-1:0] de_val;
  logic [THR_W-1:0] thr_sel;
  logic       flip_ok;

  assign ctr_spin = ctr_row_q[col_ext[AW-1:0]];
  assign lf_spin  = ctr_row_q[lf_col[AW-1:0]];
  assign rt_spin  = ctr_row_q[rt_col[AW-1:0]];
  assign up_cnt   = {2'b00, up_q} + {2'b00, dn_q};
  assign k_cnt    = up_cnt + {2'b00, lf_spin} + {2'b00, rt_spin};
  assign e_cnt    = ctr_spin ? k_cnt : 3'd4 - k_cnt;
  assign de_val   = {e_cnt, 2'b00} - DE_W'(8);

  always_comb begin
    case (e_cnt)
      3'd0:    thr_sel = thr_m8_q;
      3'd1:    thr_sel = thr_m4_q;
      3'd3:    thr_sel = thr_p4_q;
      3'd4:    thr_sel = thr_p8_q;
      default: thr_sel = THR_ONE;
    endcase
  end

  assign flip_ok = (e_cnt == 3'd2) || ({1'b0, uni_q} < thr_sel);

  // Result of the finishing step.
  logic fin_go, is_flip, is_load, acc_now, res_spin;
  logic [DE_W-1:0] res_de;
  logic [CNT_W-1:0] cnt_d;

  assign fin_go  = (state_q == ST_FIN) && (!out_valid_q || m_axis_tready_i);
  assign is_flip = (op_q == OP_FLIP) && !bad_q;
  assign is_load = (op_q == OP_LOAD) && !bad_q;
  assign acc_now = is_flip && flip_ok;

  always_comb begin
    res_spin = 1'b0;
    res_de   = '0;
    case (op_q)
      OP_LOAD: res_spin = spin_in_q;
      OP_READ: res_spin = ctr_spin;
      OP_FLIP: begin
        res_spin = ctr_spin ^ flip_ok;
        res_de   = de_val;
      end
      default: res_spin = 1'b0;
    endcase
    if (bad_q) begin
      res_spin = 1'b0;
      res_de   = '0;
    end
  end

  always_comb begin
    cnt_d = cnt_q;
    if (op_q == OP_CLEAR) begin
      cnt_d = '0;
    end else if (acc_now && (cnt_q != '1)) begin
      cnt_d = cnt_q + CNT_W'(1);
    end
  end

  // The row goes back with the site's bit replaced: the loaded spin, or the
  // old spin inverted when a flip is accepted.
  always_comb begin
    wr_data = ctr_row_q;
    wr_data[col_ext[AW-1:0]] = is_load ? spin_in_q : ~ctr_spin;
  end
  assign wr_addr = row_ext[AW-1:0];
  assign wr_en   = fin_go && (is_load || acc_now);

  // Sequencer.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          state_d = (in_bad || (in_op == OP_CLEAR)) ? ST_FIN : ST_CTR;
        end
      end
      ST_CTR:  state_d = (op_q == OP_FLIP) ? ST_UP : ST_FIN;
      ST_UP:   state_d = ST_DN;
      ST_DN:   state_d = ST_FIN;
      ST_FIN: begin
        if (fin_go) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      side_q      <= SIDE_W'(64);
      thr_m8_q    <= THR_ONE;
      thr_m4_q    <= THR_ONE;
      thr_p4_q    <= '0;
      thr_p8_q    <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_SIDE:   side_q   <= cfg_data_i[SIDE_W-1:0];
          REG_THR_M8: thr_m8_q <= cfg_data_i;
          REG_THR_M4: thr_m4_q <= cfg_data_i;
          REG_THR_P4: thr_p4_q <= cfg_data_i;
          REG_THR_P8: thr_p8_q <= cfg_data_i;
          default:    ;
        endcase
      end
      if (fin_go) begin
        cnt_q       <= cnt_d;
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      op_q      <= in_op;
      row_q     <= in_row;
      col_q     <= in_col;
      spin_in_q <= s_axis_tdata_i[12];
      uni_q     <= s_axis_tdata_i[44:13];
      bad_q     <= in_bad;
    end
    case (state_q)
      ST_CTR:  ctr_row_q <= rd_data;
      ST_UP:   up_q      <= rd_data[col_ext[AW-1:0]];
      ST_DN:   dn_q      <= rd_data[col_ext[AW-1:0]];
      default: ;
    endcase
    if (fin_go) begin
      out_spin_q <= res_spin;
      out_acc_q  <= acc_now;
      out_de_q   <= res_de;
      out_cnt_q  <= cnt_d;
      out_bad_q  <= bad_q;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {1'b0, out_cnt_q, out_de_q, out_acc_q, out_spin_q};
  assign m_axis_tuser_o  = out_bad_q;

  // The lattice is written only for a load or an attempt at a valid site.
  `IMF_ASSERT(a_write_kind, wr_en |-> (!bad_q && (op_q == OP_LOAD || op_q == OP_FLIP)), "lattice write for an item that may not write")
  // The counter moves only in the finishing step.
  `IMF_ASSERT(a_cnt_at_fin, (cnt_q != $past(cnt_q)) |-> ($past(state_q) == ST_FIN), "counter changed outside the finishing step")
  // An accepted flip in the output register came from an attempt at a valid site.
  `IMF_ASSERT(a_acc_is_flip, (fin_go && acc_now) |=> (out_acc_q && !out_bad_q && out_de_q != 5'd0 || out_acc_q && !out_bad_q), "accepted flip without a valid attempt")
  // A cycle under reset leaves the counter at zero.
  `IMF_ASSERT_ALWAYS(a_cnt_reset, !rst_ni |=> (cnt_q == '0), "counter not cleared by reset")

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the Metropolis spin-flip engine.
// ----------------------------------------------------------------------------
// Items go in on the slave stream and results come back on the master stream.
// A scoreboard keeps its own copy of the lattice, the acceptance counter and
// the register file. It works out the result of every accepted item and
// compares each returned result with the oldest one it is waiting for. A short
// hand-built sequence on a 3x3 lattice reaches every energy change and the
// bad-site and clear cases. After it come random phases, each with its own side
// and thresholds. Both streams idle at random.
// ----------------------------------------------------------------------------
module tb;
  import imf_pkg::*;

  // One input item and one result item, field by field.
  typedef struct {
    logic [1:0]  op;
    logic [5:0]  row;
    logic [5:0]  col;
    logic        spin;
    logic [31:0] uni;
  } site_req_t;

  typedef struct {
    logic              spin_out;
    logic              accepted;
    logic signed [4:0] de;
    logic [31:0]       total;
    logic              bad;
  } flip_res_t;

  // Holds the expected lattice state and the results still owed by the block.
  class flip_scoreboard;
    bit          lattice [MAX_SIDE*MAX_SIDE];
    logic [31:0] accept_cnt;
    logic [6:0]  side_reg;
    // Thresholds for energy changes -8, -4, +4 and +8, in that order.
    logic [32:0] thr [4];
    flip_res_t   outcome_q [$];
    int          errors;
    int          n_items;
    int          n_flips;
    int          n_acc;

    function new();
      accept_cnt = '0;
      side_reg   = 7'd64;
      thr[0]     = THR_ONE;
      thr[1]     = THR_ONE;
      thr[2]     = '0;
      thr[3]     = '0;
      errors     = 0;
      n_items    = 0;
      n_flips    = 0;
      n_acc      = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [32:0] val);
      case (idx)
        REG_SIDE:   side_reg = val[6:0];
        REG_THR_M8: thr[0] = val;
        REG_THR_M4: thr[1] = val;
        REG_THR_P4: thr[2] = val;
        REG_THR_P8: thr[3] = val;
        default: ;
      endcase
    endfunction

    // The side register is clamped into 2..MAX_SIDE before use.
    function int unsigned live_side();
      if (side_reg < 2) return 2;
      if (side_reg > MAX_SIDE) return MAX_SIDE;
      return side_reg;
    endfunction

    function int spin_at(int unsigned r, int unsigned c);
      return lattice[r*MAX_SIDE + c] ? 1 : -1;
    endfunction

    // Applies one accepted item to the lattice copy and queues its result.
    function void note_item(site_req_t req);
      flip_res_t   res;
      int unsigned n, r, c, up, dn, lf, rt;
      int          nsum, de;
      logic [32:0] t;
      n = live_side();
      r = req.row;
      c = req.col;
      res = '{spin_out: 1'b0, accepted: 1'b0, de: '0, total: '0, bad: 1'b0};
      res.bad = (r >= n) || (c >= n);
      n_items++;
      if (req.op == OP_CLEAR) begin
        accept_cnt = '0;
      end else if (!res.bad) begin
        case (req.op)
          OP_LOAD: begin
            lattice[r*MAX_SIDE + c] = req.spin;
            res.spin_out = req.spin;
          end
          OP_READ: res.spin_out = lattice[r*MAX_SIDE + c];
          default: begin
            up = (r == 0) ? n - 1 : r - 1;
            dn = (r + 1 == n) ? 0 : r + 1;
            lf = (c == 0) ? n - 1 : c - 1;
            rt = (c + 1 == n) ? 0 : c + 1;
            nsum = spin_at(up, c) + spin_at(dn, c) + spin_at(r, lf) + spin_at(r, rt);
            de = 2 * spin_at(r, c) * nsum;
            case (de)
              -8: t = thr[0];
              -4: t = thr[1];
              4:  t = thr[2];
              8:  t = thr[3];
              default: t = THR_ONE;
            endcase
            n_flips++;
            if (de == 0 || {1'b0, req.uni} < t) begin
              res.accepted = 1'b1;
              n_acc++;
              lattice[r*MAX_SIDE + c] = !lattice[r*MAX_SIDE + c];
              if (accept_cnt != 32'hFFFF_FFFF) accept_cnt++;
            end
            res.de = 5'(de);
            res.spin_out = lattice[r*MAX_SIDE + c];
          end
        endcase
      end
      res.total = accept_cnt;
      outcome_q.push_back(res);
    endfunction

    task report(string what);
      $display("ERROR at %0t ns: %s", $time, what);
      errors++;
    endtask

    task check_result(flip_res_t got);
      flip_res_t want;
      if (outcome_q.size() == 0) begin
        report("result arrived with no item outstanding");
      end else begin
        want = outcome_q.pop_front();
        if (got.spin_out !== want.spin_out)
          report($sformatf("spin_out %b, expected %b", got.spin_out, want.spin_out));
        if (got.accepted !== want.accepted)
          report($sformatf("accepted %b, expected %b", got.accepted, want.accepted));
        if (got.de !== want.de)
          report($sformatf("energy_change %0d, expected %0d", got.de, want.de));
        if (got.total !== want.total)
          report($sformatf("accept_total %0d, expected %0d", got.total, want.total));
        if (got.bad !== want.bad)
          report($sformatf("bad_site %b, expected %b", got.bad, want.bad));
      end
    endtask
  endclass

  localparam int IDLE_LIMIT = 4000;

  // Every input is driven to a known value from time zero.
  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_idx = REG_SIDE;
  logic [32:0] cfg_data = '0;
  logic        s_valid = 1'b0;
  logic        s_ready;
  logic [47:0] s_tdata = '0;
  logic [1:0]  s_tuser = OP_LOAD;
  logic        m_valid;
  logic        m_ready = 1'b0;
  logic [39:0] m_tdata;
  logic        m_tuser;

  // When set, neither side idles, so the block runs at full rate.
  bit          calm = 1'b0;
  // Sites loaded so far, so that reads and flips never touch an unwritten spin.
  bit          loaded [MAX_SIDE*MAX_SIDE];
  int          idle_cycles = 0;
  int          stall_left = 0;
  int          n_settings = 0;
  flip_scoreboard sb = new();

  ising_metropolis_flip u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_data_i      (cfg_data),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Idle lengths: mostly none or short, now and then a long one.
  function automatic int pick_gap();
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Result side back-pressure. The ready line changes only at falling edges.
  always @(negedge clk_i) begin
    if (calm) begin
      m_ready <= 1'b1;
      stall_left = 0;
    end else if (stall_left > 0) begin
      m_ready <= 1'b0;
      stall_left--;
    end else begin
      stall_left = pick_gap();
      if (stall_left == 0) begin
        m_ready <= 1'b1;
      end else begin
        m_ready <= 1'b0;
        stall_left--;
      end
    end
  end

  // Results are taken at rising edges, where the handshake is decided.
  always @(posedge clk_i) begin
    flip_res_t got;
    if (rst_ni && m_valid && m_ready) begin
      got.spin_out = m_tdata[0];
      got.accepted = m_tdata[1];
      got.de       = m_tdata[6:2];
      got.total    = m_tdata[38:7];
      got.bad      = m_tuser;
      sb.check_result(got);
    end
  end

  // The watchdog restarts on any handshake or register write; a long silence
  // means the block has hung.
  always @(posedge clk_i) begin
    if ((s_valid && s_ready) || (m_valid && m_ready) || cfg_we || !rst_ni) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Timeout: nothing moved for %0d cycles", IDLE_LIMIT);
      $display("Mismatches found");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Presents one item, holds it until the block takes it, then predicts it.
  // The valid line is left high; the next call or stop_items changes it.
  task automatic send_item(input logic [1:0] op, input int unsigned row,
                           input int unsigned col, input logic spin,
                           input logic [31:0] uni);
    site_req_t   req;
    int          gap;
    int unsigned n;
    req.op   = op;
    req.row  = row[5:0];
    req.col  = col[5:0];
    req.spin = spin;
    req.uni  = uni;
    n = sb.live_side();
    gap = pick_gap();
    if (gap != 0) begin
      @(negedge clk_i);
      s_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    s_valid <= 1'b1;
    s_tdata <= {3'b000, req.uni, req.spin, req.col, req.row};
    s_tuser <= req.op;
    do @(posedge clk_i); while (!s_ready);
    sb.note_item(req);
    if (op == OP_LOAD && row < n && col < n) loaded[row*MAX_SIDE + col] = 1'b1;
  endtask

  task automatic stop_items();
    @(negedge clk_i);
    s_valid <= 1'b0;
  endtask

  task automatic load_once(input int unsigned r, input int unsigned c);
    if (!loaded[r*MAX_SIDE + c]) send_item(OP_LOAD, r, c, $urandom_range(0, 1), $urandom());
  endtask

  // Before a read or a flip, loads whatever sites it will look at that have
  // never been written. A flip also looks at its four wrapped neighbours.
  task automatic prime_site(input int unsigned r, input int unsigned c, input bit nbrs);
    int unsigned n;
    n = sb.live_side();
    load_once(r, c);
    if (nbrs) begin
      load_once((r == 0) ? n - 1 : r - 1, c);
      load_once((r + 1 == n) ? 0 : r + 1, c);
      load_once(r, (c == 0) ? n - 1 : c - 1);
      load_once(r, (c + 1 == n) ? 0 : c + 1);
    end
  endtask

  // Registers change only with the block idle: the write waits until every
  // result is in.
  task automatic write_reg(input logic [2:0] idx, input logic [32:0] val);
    while (sb.outcome_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    sb.set_reg(idx, val);
    @(negedge clk_i);
    cfg_we   <= 1'b0;
  endtask

  function automatic logic [32:0] pick_thr();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 15) return '0;
    if (r < 30) return THR_ONE;
    if (r < 40) return 33'h1_FFFF_FFFF;
    if (r < 50) return THR_ONE - 1;
    return {1'b0, $urandom()};
  endfunction

  // Uniform values cluster around the thresholds so that the compare is
  // exercised right at its edge.
  function automatic logic [31:0] pick_uniform();
    int unsigned r;
    logic [32:0] t;
    logic [31:0] base;
    r = $urandom_range(0, 99);
    if (r < 30) return $urandom();
    if (r < 65) begin
      t = sb.thr[$urandom_range(0, 3)];
      base = t[32] ? 32'hFFFF_FFFF : t[31:0];
      return base + 32'($urandom_range(0, 2)) - 32'd1;
    end
    if (r < 75) return '0;
    if (r < 85) return 32'hFFFF_FFFF;
    return $urandom();
  endfunction

  task automatic random_item();
    int unsigned n, r, row, col;
    logic [1:0]  op;
    bit          bad;
    n = sb.live_side();
    r = $urandom_range(0, 99);
    if (r < 48)      op = OP_FLIP;
    else if (r < 72) op = OP_LOAD;
    else if (r < 92) op = OP_READ;
    else             op = OP_CLEAR;
    bad = (n < MAX_SIDE) && ($urandom_range(0, 99) < 12);
    row = $urandom_range(0, n - 1);
    col = $urandom_range(0, n - 1);
    if (bad) begin
      // Push one or both coordinates past the side.
      case ($urandom_range(0, 2))
        0: row = $urandom_range(n, MAX_SIDE - 1);
        1: col = $urandom_range(n, MAX_SIDE - 1);
        default: begin
          row = $urandom_range(n, MAX_SIDE - 1);
          col = $urandom_range(n, MAX_SIDE - 1);
        end
      endcase
    end else if (op == OP_READ || op == OP_FLIP) begin
      prime_site(row, col, op == OP_FLIP);
    end
    send_item(op, row, col, $urandom_range(0, 1), pick_uniform());
  endtask

  // Side values per phase: clamped low and high values are among them, as are
  // the exact limits 2 and 64.
  int unsigned phase_side [12] = '{2, 0, 3, 5, 1, 8, 127, 4, 64, 6, 16, 100};

  initial begin
    logic [32:0] tv;
    int          base_items;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed part on a 3x3 lattice with the reset thresholds: -8 and -4
    // always accept, +4 and +8 never do.
    write_reg(REG_SIDE, 33'd3);
    n_settings++;
    for (int r = 0; r < 3; r++)
      for (int c = 0; c < 3; c++)
        send_item(OP_LOAD, r, c, 1'b1, 32'h0);
    // All neighbours agree: +8, rejected even with the smallest uniform.
    send_item(OP_FLIP, 0, 0, 1'b0, 32'h0);
    // Read of the corner site.
    send_item(OP_READ, 2, 2, 1'b0, 32'hFFFF_FFFF);
    // A lone down spin: -8, accepted even with the largest uniform.
    send_item(OP_LOAD, 1, 1, 1'b0, 32'h0);
    send_item(OP_FLIP, 1, 1, 1'b1, 32'hFFFF_FFFF);
    // One disagreeing neighbour gives +4, rejected.
    send_item(OP_LOAD, 0, 1, 1'b0, 32'h0);
    send_item(OP_FLIP, 1, 1, 1'b0, 32'h0);
    // Two up and two down neighbours: zero change, flips both ways.
    send_item(OP_LOAD, 2, 1, 1'b0, 32'h0);
    send_item(OP_FLIP, 1, 1, 1'b0, 32'hFFFF_FFFF);
    send_item(OP_FLIP, 1, 1, 1'b0, 32'hFFFF_FFFF);
    // Three down neighbours around an up spin: -4, accepted.
    send_item(OP_LOAD, 1, 0, 1'b0, 32'h0);
    send_item(OP_FLIP, 1, 1, 1'b0, 32'h8000_0000);
    // Coordinates past the side: nothing changes and the site is flagged.
    send_item(OP_FLIP, 63, 0, 1'b1, 32'h0);
    send_item(OP_LOAD, 0, 3, 1'b1, 32'h0);
    send_item(OP_READ, 5, 2, 1'b0, 32'h0);
    // A clear works whatever the site, and still reports the check.
    send_item(OP_CLEAR, 63, 63, 1'b1, 32'hFFFF_FFFF);
    send_item(OP_CLEAR, 0, 0, 1'b0, 32'h0);
    send_item(OP_READ, 1, 1, 1'b0, 32'h0);
    stop_items();
    base_items = sb.n_items;

    // Random phases. Each rewrites every register; the first two pin all
    // thresholds to their extremes, and every fourth phase runs without idling.
    // Each phase sends about 56 items, the loads that prepare a site included.
    for (int ph = 0; ph < 12; ph++) begin
      write_reg(REG_SIDE, 33'(phase_side[ph]));
      for (int k = 0; k < 4; k++) begin
        if (ph == 0)      tv = 33'h1_FFFF_FFFF;
        else if (ph == 1) tv = '0;
        else              tv = pick_thr();
        write_reg(3'(REG_THR_M8 + k), tv);
      end
      n_settings++;
      calm = (ph % 4 == 3);
      while (sb.n_items < base_items + 56 * (ph + 1)) random_item();
      stop_items();
      calm = 1'b0;
    end

    // Drain, then give the block time to show any stray result.
    while (sb.outcome_q.size() != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);

    $display("Ran %0d items under %0d register settings.", sb.n_items, n_settings);
    $display("Flip attempts: %0d, of which %0d flipped; %0d field errors.",
             sb.n_flips, sb.n_acc, sb.errors);
    if (sb.errors == 0 && sb.outcome_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+sv
sv/imf_pkg.sv
sv/imf_ram.sv
sv/ising_metropolis_flip.sv
test/tb.sv
